// ===== sv/brc_pkg.sv =====
package brc_pkg;

    localparam int IDX_W        = 12;
    localparam int LEVEL_W      = 3;
    localparam int CFG_W        = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int REM_W        = 2;
    localparam int LEVEL_LIMIT  = 6;

    localparam int DEF_MAX_LEVELS  = 6;
    localparam int DEF_INDEX_WIDTH = 12;

    localparam logic [CFG_W-1:0] FANOUT_RESET = 3'd2;
    localparam logic [CFG_W-1:0] TOP_RESET    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic emit_err;
        logic walk;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic range_bad;
        logic walk_final;
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } divmod_t;

endpackage

// ===== sv/brc_ctrl.sv =====
module brc_ctrl
    import brc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                // A rejected range gives its single error item as soon as the
                // output register has room.
                if (status.range_bad) begin
                    if (status.slot_free) begin
                        cmd.emit_err = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.slot_free) begin
                    cmd.walk = 1'b1;
                    if (status.walk_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/brc_datapath.sv =====
module brc_datapath
    import brc_pkg::*;
#(
    parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [IDX_W-1:0]     s_range_first,
    input  logic [IDX_W-1:0]     s_range_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEVEL_W-1:0]   m_node_level,
    output logic [IDX_W-1:0]     m_node_index,
    output logic                 m_last_node,
    output logic                 m_range_error,
    input  cmd_t                 cmd,
    output status_t              status
);

    localparam logic [IDX_W-1:0]   INDEX_MASK = {IDX_W{1'b1}} >> (IDX_W - INDEX_WIDTH);
    localparam logic [LEVEL_W-1:0] TOP_LIMIT  = LEVEL_W'(MAX_LEVELS);

    // Number of leaves of a tree with the given fanout and height. The fanout
    // is always 2, 3 or 4 here, so powers of two are shifts and powers of
    // three come from a short table.
    function automatic logic [IDX_W:0] tree_leaves(input logic [CFG_W-1:0] f,
                                                   input logic [LEVEL_W-1:0] t);
        logic [IDX_W:0] p;
        p = '0;
        case (f)
            3'd2: begin
                p = (IDX_W + 1)'(1) << t;
            end
            3'd3: begin
                case (t)
                    3'd0:    p = (IDX_W + 1)'(1);
                    3'd1:    p = (IDX_W + 1)'(3);
                    3'd2:    p = (IDX_W + 1)'(9);
                    3'd3:    p = (IDX_W + 1)'(27);
                    3'd4:    p = (IDX_W + 1)'(81);
                    3'd5:    p = (IDX_W + 1)'(243);
                    default: p = (IDX_W + 1)'(729);
                endcase
            end
            default: begin
                p = (IDX_W + 1)'(1) << {t, 1'b0};
            end
        endcase
        return p;
    endfunction

    // Quotient and remainder by a fanout of 2, 3 or 4. Division by three uses
    // the reciprocal 2731/8192, which is exact for every 12-bit value.
    function automatic divmod_t split_by_fanout(input logic [IDX_W-1:0] x,
                                                input logic [CFG_W-1:0] f);
        divmod_t          res;
        logic [23:0]      prod;
        logic [IDX_W-1:0] q3;
        prod = 24'(x) * 24'd2731;
        res  = '0;
        q3   = '0;
        case (f)
            3'd2: begin
                res.quo = x >> 1;
                res.rem = {1'b0, x[0]};
            end
            3'd3: begin
                res.quo = IDX_W'(prod[23:13]);
                q3      = (res.quo << 1) + res.quo;
                res.rem = REM_W'(x - q3);
            end
            default: begin
                res.quo = x >> 2;
                res.rem = x[1:0];
            end
        endcase
        return res;
    endfunction

    logic [CFG_W-1:0]   fanout_reg, top_reg;
    logic [CFG_W-1:0]   fanout_eff;
    logic [LEVEL_W-1:0] top_eff;

    logic [IDX_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               right_reg, right_next;

    logic               valid_reg, valid_next;
    logic [LEVEL_W-1:0] olevel_reg, olevel_next;
    logic [IDX_W-1:0]   oindex_reg, oindex_next;
    logic               olast_reg, olast_next;
    logic               oerr_reg, oerr_next;

    divmod_t            lo_dm, hi_dm;
    logic               at_top, lo_lt_hi, take_left, take_right, finish, emit;
    logic [REM_W-1:0]   last_child;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fanout_reg <= FANOUT_RESET;
            top_reg    <= TOP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FANOUT: fanout_reg <= cfg_data;
                CFG_TOP:    top_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign fanout_eff = (fanout_reg < 3'd2) ? 3'd2 : ((fanout_reg > 3'd4) ? 3'd4 : fanout_reg);
    assign top_eff    = (top_reg > TOP_LIMIT) ? TOP_LIMIT : top_reg;
    assign last_child = REM_W'(fanout_eff - 3'd1);

    assign lo_dm    = split_by_fanout(lo_reg, fanout_eff);
    assign hi_dm    = split_by_fanout(hi_reg, fanout_eff);
    assign at_top   = (level_reg == top_eff);
    assign lo_lt_hi = (lo_reg < hi_reg);

    // The left end walks first; once it stops, only the right end walks
    // until both ends climb together.
    assign take_left  = !right_reg && (lo_dm.rem != '0 || at_top) && lo_lt_hi;
    assign take_right = !take_left && (hi_dm.rem != last_child || at_top) && lo_lt_hi;
    assign finish     = !take_left && !take_right && ((lo_reg == hi_reg) || at_top);
    assign emit       = cmd.emit_err || (cmd.walk && (take_left || take_right || finish));

    always_comb begin
        status.slot_free  = !valid_reg || m_ready;
        status.range_bad  = (lo_reg > hi_reg) ||
                            ({1'b0, hi_reg} >= tree_leaves(fanout_eff, top_eff));
        status.walk_final = finish;
    end

    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        level_next = level_reg;
        right_next = right_reg;
        if (cmd.load) begin
            lo_next    = s_range_first;
            hi_next    = s_range_last;
            level_next = '0;
            right_next = 1'b0;
        end else if (cmd.walk) begin
            if (take_left) begin
                lo_next = lo_reg + 1'b1;
            end else if (take_right) begin
                hi_next    = hi_reg - 1'b1;
                right_next = 1'b1;
            end else if (!finish) begin
                lo_next    = lo_dm.quo;
                hi_next    = hi_dm.quo;
                level_next = level_reg + 1'b1;
                right_next = 1'b0;
            end
        end
    end

    always_comb begin
        valid_next  = valid_reg;
        olevel_next = olevel_reg;
        oindex_next = oindex_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        if (emit) begin
            valid_next = 1'b1;
            if (cmd.emit_err) begin
                olevel_next = '0;
                oindex_next = '0;
                olast_next  = 1'b1;
                oerr_next   = 1'b1;
            end else begin
                olevel_next = level_reg;
                oindex_next = (take_right ? hi_reg : lo_reg) & INDEX_MASK;
                olast_next  = finish;
                oerr_next   = 1'b0;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            right_reg <= 1'b0;
            level_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            right_reg <= right_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        olevel_reg <= olevel_next;
        oindex_reg <= oindex_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    assign m_valid       = valid_reg;
    assign m_node_level  = olevel_reg;
    assign m_node_index  = oindex_reg;
    assign m_last_node   = olast_reg;
    assign m_range_error = oerr_reg;

endmodule

// ===== sv/best_range_cover_core.sv =====
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_range_first, s_range_last
// m_        out        m_valid / m_ready   m_node_level, m_node_index, m_last_node,
//                                          m_range_error
// cfg_      in         cfg_wr_en           cfg_index, cfg_data
//
// An item is accepted while idle, its range is checked in the setup state, and the walk then
// gives one cover node per cycle while the output has room; at most 37 nodes, 6 level climbs.
// The walk sequencer handles one range at a time; s_ready is high only while it is idle.
// A full output register that is not taken stalls the walk, one node per free slot.
// Reset is synchronous and active low; it restores fanout 2 and top level 6.
module best_range_cover_core
    import brc_pkg::*;
#(
    parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_range_first,
    input  logic [IDX_W-1:0]     s_range_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEVEL_W-1:0]   m_node_level,
    output logic [IDX_W-1:0]     m_node_index,
    output logic                 m_last_node,
    output logic                 m_range_error
);

    cmd_t    cmd;
    status_t status;

    brc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    brc_datapath #(
        .MAX_LEVELS  (MAX_LEVELS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_range_first (s_range_first),
        .s_range_last  (s_range_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_node_level  (m_node_level),
        .m_node_index  (m_node_index),
        .m_last_node   (m_last_node),
        .m_range_error (m_range_error),
        .cmd           (cmd),
        .status        (status)
    );

    // The sequencer never advances into a full output register.
    a_walk_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.walk || cmd.emit_err) |-> status.slot_free)
        else $error("walk step issued without a free output slot");

    // An error item and a walk step are never issued together.
    a_single_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.walk && cmd.emit_err))
        else $error("error item and walk step in the same cycle");

    // After an item is accepted the block is busy for at least the setup cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a range is still being walked");

    // A rejected range always closes with its single error item.
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_range_error) |-> m_last_node)
        else $error("error item not marked as last");

endmodule

// ===== sim/best_range_cover_core_tb.sv =====
`timescale 1ns / 1ps

module best_range_cover_core_tb
    import brc_pkg::*;
();

    localparam int MAX_NODES    = 37;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PERCENT = 21;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 36;

    typedef struct packed {
        logic [LEVEL_W-1:0] node_level;
        logic [IDX_W-1:0]   node_index;
        logic               last_node;
        logic               range_error;
    } cover_node_t;

    typedef struct packed {
        logic [CFG_W-1:0] fan;
        logic [CFG_W-1:0] top_lv;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        logic             typed;
        cover_node_t      node;
    } dir_row_t;

    localparam cover_node_t RANGE_ERR = '{3'd0, 12'd0, 1'b1, 1'b1};
    localparam cover_node_t NO_NODE   = '0;

    // Rows with a typed node produce exactly that single node; the rest go
    // through the predictor.
    localparam int N_DIRECTED = 24;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{3'd2, 3'd6, 12'd0,    12'd0,    1'b1, '{3'd0, 12'd0,    1'b1, 1'b0}},
        '{3'd2, 3'd6, 12'd63,   12'd63,   1'b1, '{3'd0, 12'd63,   1'b1, 1'b0}},
        '{3'd2, 3'd6, 12'd0,    12'd63,   1'b1, '{3'd6, 12'd0,    1'b1, 1'b0}},
        '{3'd2, 3'd6, 12'd5,    12'd4,    1'b1, RANGE_ERR},
        '{3'd2, 3'd6, 12'd0,    12'd64,   1'b1, RANGE_ERR},
        '{3'd2, 3'd6, 12'd4095, 12'd4095, 1'b1, RANGE_ERR},
        '{3'd2, 3'd6, 12'd1,    12'd62,   1'b0, NO_NODE},
        '{3'd2, 3'd6, 12'd31,   12'd32,   1'b0, NO_NODE},
        '{3'd2, 3'd6, 12'd0,    12'd62,   1'b0, NO_NODE},
        '{3'd4, 3'd6, 12'd0,    12'd4095, 1'b1, '{3'd6, 12'd0,    1'b1, 1'b0}},
        '{3'd4, 3'd6, 12'd1,    12'd4094, 1'b0, NO_NODE},
        '{3'd4, 3'd6, 12'd4095, 12'd0,    1'b1, RANGE_ERR},
        '{3'd4, 3'd6, 12'd2730, 12'd3413, 1'b0, NO_NODE},
        '{3'd4, 3'd6, 12'd4095, 12'd4095, 1'b1, '{3'd0, 12'd4095, 1'b1, 1'b0}},
        '{3'd3, 3'd6, 12'd0,    12'd729,  1'b1, RANGE_ERR},
        '{3'd3, 3'd6, 12'd0,    12'd728,  1'b1, '{3'd6, 12'd0,    1'b1, 1'b0}},
        '{3'd4, 3'd0, 12'd0,    12'd0,    1'b1, '{3'd0, 12'd0,    1'b1, 1'b0}},
        '{3'd4, 3'd0, 12'd0,    12'd1,    1'b1, RANGE_ERR},
        '{3'd0, 3'd2, 12'd0,    12'd3,    1'b1, '{3'd2, 12'd0,    1'b1, 1'b0}},
        '{3'd5, 3'd3, 12'd0,    12'd64,   1'b1, RANGE_ERR},
        '{3'd3, 3'd1, 12'd0,    12'd2,    1'b1, '{3'd1, 12'd0,    1'b1, 1'b0}},
        '{3'd3, 3'd1, 12'd1,    12'd2,    1'b0, NO_NODE},
        '{3'd7, 3'd7, 12'd1365, 12'd1366, 1'b0, NO_NODE},
        '{3'd1, 3'd7, 12'd3,    12'd60,   1'b0, NO_NODE}
    };

    localparam logic [CFG_W-1:0] PHASE_FAN [N_PHASES] =
        '{3'd2, 3'd4, 3'd3, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd6};
    localparam logic [CFG_W-1:0] PHASE_TOP [N_PHASES] =
        '{3'd6, 3'd6, 3'd6, 3'd0, 3'd7, 3'd3, 3'd2, 3'd1, 3'd5, 3'd4};

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_FANOUT;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [IDX_W-1:0]     s_range_first = '0;
    logic [IDX_W-1:0]     s_range_last  = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [LEVEL_W-1:0]   m_node_level;
    logic [IDX_W-1:0]     m_node_index;
    logic                 m_last_node;
    logic                 m_range_error;

    best_range_cover_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_first (s_range_first),
        .s_range_last  (s_range_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_node_level  (m_node_level),
        .m_node_index  (m_node_index),
        .m_last_node   (m_last_node),
        .m_range_error (m_range_error)
    );

    // Register shadows, updated whenever the testbench writes the block.
    logic [CFG_W-1:0] fanout_cfg = FANOUT_RESET;
    logic [CFG_W-1:0] top_cfg    = TOP_RESET;

    cover_node_t pending_nodes[$];
    cover_node_t want_node;
    cover_node_t got_node;

    int n_ranges  = 0;
    int n_nodes   = 0;
    int n_rejects = 0;
    int n_fail    = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned eff_fanout();
        if (fanout_cfg < 2) return 2;
        if (fanout_cfg > 4) return 4;
        return int'(fanout_cfg);
    endfunction

    function automatic int unsigned eff_top();
        return (top_cfg > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : int'(top_cfg);
    endfunction

    function automatic int unsigned leaf_count();
        int unsigned leaves;
        leaves = 1;
        for (int i = 0; i < eff_top(); i++) leaves *= eff_fanout();
        return leaves;
    endfunction

    function automatic void push_node(int unsigned lvl, int unsigned idx,
                                      bit fin, bit err);
        cover_node_t nd;
        nd.node_level  = LEVEL_W'(lvl);
        nd.node_index  = IDX_W'(idx);
        nd.last_node   = fin;
        nd.range_error = err;
        pending_nodes  = {pending_nodes, nd};
    endfunction

    // Walks both ends of the range up the tree and queues the cover nodes in
    // the order the block emits them.
    function automatic void predict_cover(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
        int unsigned f;
        int unsigned top;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        bit at_top;
        f   = eff_fanout();
        top = eff_top();
        lo  = first;
        hi  = last;
        n   = 0;
        if (lo > hi || hi >= leaf_count()) begin
            push_node(0, 0, 1'b1, 1'b1);
            return;
        end
        for (int unsigned lvl = 0; lvl <= top; lvl++) begin
            at_top = (lvl == top);
            while (((lo % f) != 0 || at_top) && lo < hi && n < MAX_NODES - 1) begin
                push_node(lvl, lo, 1'b0, 1'b0);
                lo++;
                n++;
            end
            while (((hi % f) != f - 1 || at_top) && lo < hi && n < MAX_NODES - 1) begin
                push_node(lvl, hi, 1'b0, 1'b0);
                hi--;
                n++;
            end
            if (lo == hi || at_top) begin
                push_node(lvl, lo, 1'b1, 1'b0);
                return;
            end
            lo = lo / f;
            hi = hi / f;
        end
    endfunction

    function automatic bit calm_stretch();
        return n_ranges >= 200 && n_ranges < 260;
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_range(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
                              bit typed, cover_node_t typed_node);
        while (!calm_stretch() && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_range_first <= first;
        s_range_last  <= last;
        do @(posedge aclk); while (!s_ready);
        if (typed) pending_nodes = {pending_nodes, typed_node};
        else predict_cover(first, last);
        n_ranges++;
    endtask

    // Registers are only touched once every node has drained and the block
    // is back to accepting ranges.
    task automatic apply_settings(logic [CFG_W-1:0] fan, logic [CFG_W-1:0] top_lv);
        if (fan == fanout_cfg && top_lv == top_cfg) return;
        s_valid <= 1'b0;
        while (pending_nodes.size() != 0 || !s_ready) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FANOUT;
        cfg_data  <= fan;
        @(posedge aclk);
        cfg_index <= CFG_TOP;
        cfg_data  <= top_lv;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        fanout_cfg = fan;
        top_cfg    = top_lv;
    endtask

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d nodes outstanding", $time,
                     pending_nodes.size());
            $display("best_range_cover_core verification failed");
            $finish;
        end
    end

    // The receiver: random back-pressure, one long hold-off once the sender
    // is well into the random ranges, and a calm stretch.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && n_ranges >= 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_node = '{m_node_level, m_node_index, m_last_node, m_range_error};
            if (pending_nodes.size() == 0) begin
                $display("%0t ns: unexpected node, expected none, got %p",
                         $time, got_node);
                n_fail++;
            end else begin
                want_node = pending_nodes.pop_front();
                n_nodes++;
                if (want_node.range_error) n_rejects++;
                if (got_node !== want_node) begin
                    $display("%0t ns: node mismatch, expected %p, got %p",
                             $time, want_node, got_node);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        int unsigned leaves;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            apply_settings(DIRECTED[r].fan, DIRECTED[r].top_lv);
            send_range(DIRECTED[r].first, DIRECTED[r].last, DIRECTED[r].typed,
                       DIRECTED[r].node);
        end

        // Mostly well-formed ranges inside the tree, with some arbitrary
        // pairs that are usually rejected.
        for (int p = 0; p < N_PHASES; p++) begin
            apply_settings(PHASE_FAN[p], PHASE_TOP[p]);
            leaves = leaf_count();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 15) begin
                    lo = $urandom_range(0, 4095);
                    hi = $urandom_range(0, 4095);
                end else begin
                    lo = $urandom_range(0, leaves - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        hi = $urandom_range(lo, leaves - 1);
                    end else begin
                        span = $urandom_range(0, 8);
                        hi   = (lo + span < leaves) ? lo + span : leaves - 1;
                    end
                end
                send_range(IDX_W'(lo), IDX_W'(hi), 1'b0, NO_NODE);
            end
        end

        s_valid <= 1'b0;
        while (pending_nodes.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Covered %0d ranges from the directed rows and %0d random phases, %0d nodes",
                 n_ranges, N_PHASES, n_nodes);
        $display("of which %0d were rejected ranges; %0d failures seen.",
                 n_rejects, n_fail);
        if (n_fail == 0) begin
            $display("best_range_cover_core verification clean");
        end else begin
            $display("best_range_cover_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/brc_pkg.sv
sv/brc_ctrl.sv
sv/brc_datapath.sv
sv/best_range_cover_core.sv
sim/best_range_cover_core_tb.sv
